@@ sv/ttfd_pkg.sv @@
package ttfd_pkg;

	localparam int NUM_PCT = 8;
	localparam int NUM_SET = NUM_PCT + 1;
	localparam int QDEPTH  = 2;

	typedef logic [13:0] power_t;
	typedef logic [6:0]  pct_t;
	typedef logic [3:0]  ctrl_id_t;

	typedef struct packed {
		power_t                   power;
		pct_t [NUM_PCT-1:0]       pct;
	} settings_t;

	typedef struct packed {
		logic [13:0] power_deadband;
		logic [6:0]  percent_deadband;
		logic [7:0]  kerb_surface_code;
		logic [7:0]  axis_number;
	} cfg_t;

	typedef enum logic [1:0] {
		REG_POWER_DB   = 2'd0,
		REG_PERCENT_DB = 2'd1,
		REG_KERB_CODE  = 2'd2,
		REG_AXIS       = 2'd3
	} cfg_reg_t;

	localparam cfg_t CFG_RESET = '{
		power_deadband:    14'd200,
		percent_deadband:  7'd3,
		kerb_surface_code: 8'd1,
		axis_number:       8'd0
	};

	localparam ctrl_id_t ID_POWER     = 4'd0;
	localparam ctrl_id_t ID_LAST_AXIS = 4'd4;
	localparam ctrl_id_t ID_LAST      = 4'd8;

	localparam logic [14:0] POWER_BASE  = 15'd6500;
	localparam logic [14:0] BRAKE_GAIN  = 15'd35;
	localparam logic [14:0] ACCEL_GAIN  = 15'd20;
	localparam logic [14:0] ABS_BOOST   = 15'd500;
	localparam logic [14:0] TC_BOOST    = 15'd300;
	localparam logic [14:0] POWER_MAX   = 15'd14000;
	localparam logic [14:0] POWER_MIN   = 15'd3500;
	localparam pct_t        PCT_MAX     = 7'd100;
	localparam pct_t        SPRING_BASE = 7'd80;
	localparam pct_t        SPRING_MIN  = 7'd15;
	localparam pct_t        ABS_INERTIA = 7'd25;
	localparam pct_t        TC_INERTIA  = 7'd20;
	localparam pct_t        BASE_20     = 7'd20;
	localparam pct_t        BASE_30     = 7'd30;
	localparam pct_t        BASE_40     = 7'd40;
	localparam pct_t        KERB_ADD    = 7'd30;

endpackage

@@ sv/telemetry_to_feedback_deadband.sv @@
// an accepted item reaches its first result through the input stage, queue, emit stage and output register
// one result per cycle while out_stall is low; an item gives 0 to 9 results
// an item with no results still passes through the emit stage
// a two-entry queue lets the input stage keep taking items while results wait
// arst_n clears control state and sent values; registers return to their reset values
module telemetry_to_feedback_deadband import ttfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [13:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [9:0]  vehicle_speed,
	input  logic [6:0]  brake_percent,
	input  logic [6:0]  accel_percent,
	input  logic        abs_on,
	input  logic        traction_on,
	input  logic [7:0]  rumble_level,
	input  logic [7:0]  shift_level,
	input  logic [7:0]  surface_code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  control_id,
	output logic [13:0] setting_value,
	output logic [7:0]  axis_index,
	output logic        last_of_run
);

	cfg_t      cfg_q;
	logic      push_valid, push_ready, pop_valid, pop_ready;
	settings_t push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_POWER_DB:   cfg_q.power_deadband    <= cfg_data;
				REG_PERCENT_DB: cfg_q.percent_deadband  <= cfg_data[6:0];
				REG_KERB_CODE:  cfg_q.kerb_surface_code <= cfg_data[7:0];
				REG_AXIS:       cfg_q.axis_number       <= cfg_data[7:0];
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	ttfd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.vehicle_speed (vehicle_speed),
		.brake_percent (brake_percent),
		.accel_percent (accel_percent),
		.abs_on        (abs_on),
		.traction_on   (traction_on),
		.rumble_level  (rumble_level),
		.shift_level   (shift_level),
		.surface_code  (surface_code),
		.push_valid    (push_valid),
		.push_data     (push_data),
		.push_ready    (push_ready)
	);

	ttfd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	ttfd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.pop_valid     (pop_valid),
		.pop_data      (pop_data),
		.pop_ready     (pop_ready),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.control_id    (control_id),
		.setting_value (setting_value),
		.axis_index    (axis_index),
		.last_of_run   (last_of_run)
	);

endmodule

@@ sv/ttfd_front.sv @@
module ttfd_front import ttfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [9:0] vehicle_speed,
	input  logic [6:0] brake_percent,
	input  logic [6:0] accel_percent,
	input  logic       abs_on,
	input  logic       traction_on,
	input  logic [7:0] rumble_level,
	input  logic [7:0] shift_level,
	input  logic [7:0] surface_code,
	output logic       push_valid,
	output settings_t  push_data,
	input  logic       push_ready
);

	logic       valid_s1;
	logic [6:0] brake_s1, accel_s1, rpct_s1, spct_s1;
	logic       abs_s1, tc_s1, kerb_s1;
	logic [7:0] spd6_s1;
	logic [5:0] spd25_s1;
	logic       advance;

	logic [14:0] rum_prod, shf_prod, rum_sum, shf_sum;
	logic [19:0] spd6_prod;
	logic [15:0] spd25_prod;

	logic [12:0] b6_prod;
	logic [14:0] a3_prod, r3_prod, power_sum;
	logic [7:0]  damper_sum;

	assign advance  = !valid_s1 || push_ready;
	assign in_stall = !advance;

	// x*100/255, speed/6 and speed/25 via reciprocals, exact over these input ranges
	always_comb begin
		rum_prod   = {7'd0, rumble_level} * 15'd100;
		shf_prod   = {7'd0, shift_level} * 15'd100;
		rum_sum    = rum_prod + {8'd0, rum_prod[14:8]} + 15'd1;
		shf_sum    = shf_prod + {8'd0, shf_prod[14:8]} + 15'd1;
		spd6_prod  = {10'd0, vehicle_speed} * 20'd683;
		spd25_prod = {6'd0, vehicle_speed} * 16'd41;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			brake_s1 <= brake_percent;
			accel_s1 <= accel_percent;
			abs_s1   <= abs_on;
			tc_s1    <= traction_on;
			kerb_s1  <= (surface_code == cfg.kerb_surface_code);
			rpct_s1  <= rum_sum[14:8];
			spct_s1  <= shf_sum[14:8];
			spd6_s1  <= spd6_prod[19:12];
			spd25_s1 <= spd25_prod[15:10];
		end
	end

	always_comb begin
		b6_prod = {6'd0, brake_s1} * 13'd43;
		a3_prod = {8'd0, accel_s1} * 15'd171;
		r3_prod = {8'd0, rpct_s1} * 15'd171;

		power_sum = POWER_BASE + {8'd0, brake_s1} * BRAKE_GAIN
			+ {8'd0, accel_s1} * ACCEL_GAIN
			+ (abs_s1 ? ABS_BOOST : 15'd0) + (tc_s1 ? TC_BOOST : 15'd0);
		push_data.power = (power_sum > POWER_MAX) ? POWER_MAX[13:0] : power_sum[13:0];

		// idle spring
		if (spd6_s1 >= 8'd65) begin
			push_data.pct[0] = SPRING_MIN;
		end else begin
			push_data.pct[0] = SPRING_BASE - spd6_s1[6:0];
		end

		damper_sum = {1'b0, BASE_20} + {2'd0, brake_s1[6:1]} + {2'd0, spd25_s1};
		push_data.pct[1] = (damper_sum > {1'b0, PCT_MAX}) ? PCT_MAX : damper_sum[6:0];

		push_data.pct[2] = {1'b0, rpct_s1[6:1]} + (kerb_s1 ? KERB_ADD : 7'd0);
		push_data.pct[3] = (abs_s1 ? ABS_INERTIA : 7'd0) + (tc_s1 ? TC_INERTIA : 7'd0)
			+ {2'd0, b6_prod[12:8]};
		push_data.pct[4] = BASE_40 + {2'd0, spct_s1[6:2]};
		push_data.pct[5] = BASE_20 + {1'b0, brake_s1[6:1]};
		push_data.pct[6] = BASE_30 + {1'b0, r3_prod[14:9]};
		push_data.pct[7] = BASE_20 + {1'b0, a3_prod[14:9]};
	end

	assign push_valid = valid_s1;

endmodule

@@ sv/ttfd_queue.sv @@
module ttfd_queue import ttfd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	input  settings_t push_data,
	output logic      push_ready,
	output logic      pop_valid,
	output settings_t pop_data,
	input  logic      pop_ready
);

	localparam int AW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);

	settings_t       entry_q [QDEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	assign push_ready = (count_q != CW'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ sv/ttfd_back.sv @@
module ttfd_back import ttfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        pop_valid,
	input  settings_t   pop_data,
	output logic        pop_ready,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  control_id,
	output logic [13:0] setting_value,
	output logic [7:0]  axis_index,
	output logic        last_of_run
);

	logic                have_sent_q;
	power_t              sent_power_q;
	pct_t [NUM_PCT-1:0]  sent_pct_q;
	settings_t           val_q;
	logic [NUM_SET-1:0]  mask_q, new_mask, low_bit, mask_after;
	ctrl_id_t            idx;
	logic                fire, load;
	logic                out_valid_q;
	ctrl_id_t            id_q;
	logic [13:0]         value_q;
	logic [7:0]          axis_q;
	logic                last_q;
	power_t              pdiff;
	pct_t                cdiff;
	logic [2:0]          pct_sel;

	always_comb begin
		idx = ID_POWER;
		for (int i = NUM_SET - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				idx = ctrl_id_t'(i);
			end
		end
		low_bit    = NUM_SET'(1) << idx;
		fire       = (|mask_q) && (!out_valid_q || !out_stall);
		mask_after = fire ? (mask_q & ~low_bit) : mask_q;
		pop_ready  = ~|mask_after;
		load       = pop_valid && pop_ready;
		pct_sel    = 3'(idx - 4'd1);
	end

	always_comb begin
		pdiff = (pop_data.power >= sent_power_q) ? pop_data.power - sent_power_q
			: sent_power_q - pop_data.power;
		new_mask[0] = !have_sent_q || (pdiff >= cfg.power_deadband);
		for (int i = 0; i < NUM_PCT; i++) begin
			cdiff = (pop_data.pct[i] >= sent_pct_q[i]) ? pop_data.pct[i] - sent_pct_q[i]
				: sent_pct_q[i] - pop_data.pct[i];
			new_mask[i+1] = !have_sent_q || (cdiff >= cfg.percent_deadband);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_sent_q  <= 1'b0;
			sent_power_q <= '0;
			sent_pct_q   <= '0;
			mask_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (load) begin
				have_sent_q <= 1'b1;
				mask_q      <= new_mask;
				if (new_mask[0]) begin
					sent_power_q <= pop_data.power;
				end
				for (int i = 0; i < NUM_PCT; i++) begin
					if (new_mask[i+1]) begin
						sent_pct_q[i] <= pop_data.pct[i];
					end
				end
			end else begin
				mask_q <= mask_after;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			val_q <= pop_data;
		end
		if (fire) begin
			id_q    <= idx;
			value_q <= (idx == ID_POWER) ? val_q.power : {7'd0, val_q.pct[pct_sel]};
			axis_q  <= (idx <= ID_LAST_AXIS) ? cfg.axis_number : 8'd0;
			last_q  <= ~|(mask_q & ~low_bit);
		end
	end

	assign out_valid     = out_valid_q;
	assign control_id    = id_q;
	assign setting_value = value_q;
	assign axis_index    = axis_q;
	assign last_of_run   = last_q;

endmodule

@@ sv/ttfd_checker.sv @@
module ttfd_checker import ttfd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [3:0]  control_id,
	input logic [13:0] setting_value,
	input logic [7:0]  axis_index,
	input logic        last_of_run
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(control_id)
			&& $stable(setting_value) && $stable(axis_index) && $stable(last_of_run))
		else $error("stalled result changed");

	// results of one run follow directly, ids ascending
	a_run_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_run |=> out_valid
			&& (control_id > $past(control_id)))
		else $error("run broken or out of order");

	// effect settings carry no axis
	a_effect_axis: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (control_id > ID_LAST_AXIS) |-> axis_index == 8'd0)
		else $error("effect setting with axis");

	// values stay in range for their setting
	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (control_id <= ID_LAST)
			&& ((control_id == ID_POWER)
				? (setting_value >= POWER_MIN[13:0] && setting_value <= POWER_MAX[13:0])
				: (setting_value <= {7'd0, PCT_MAX})))
		else $error("setting value out of range");

endmodule

bind telemetry_to_feedback_deadband ttfd_checker u_ttfd_checker (.*);

@@ test/tb_telemetry_to_feedback_deadband.sv @@
module tb_telemetry_to_feedback_deadband;
	timeunit 1ns;
	timeprecision 1ps;
	import ttfd_pkg::*;

	typedef struct packed {
		logic [9:0] vehicle_speed;
		logic [6:0] brake_percent;
		logic [6:0] accel_percent;
		logic       abs_on;
		logic       traction_on;
		logic [7:0] rumble_level;
		logic [7:0] shift_level;
		logic [7:0] surface_code;
	} sample_t;

	typedef struct packed {
		ctrl_id_t    control_id;
		logic [13:0] setting_value;
		logic [7:0]  axis_index;
		logic        last_of_run;
	} setting_msg_t;

	class feedback_scoreboard;
		cfg_t         cfg;
		power_t       last_power;
		pct_t         last_pct [NUM_PCT];
		bit           primed;
		setting_msg_t pending_q [$];
		int           errors;

		function new();
			cfg = CFG_RESET;
			last_power = '0;
			foreach (last_pct[i]) last_pct[i] = '0;
			primed = 1'b0;
			errors = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [13:0] data);
			case (idx)
				REG_POWER_DB:   cfg.power_deadband = data;
				REG_PERCENT_DB: cfg.percent_deadband = data[6:0];
				REG_KERB_CODE:  cfg.kerb_surface_code = data[7:0];
				REG_AXIS:       cfg.axis_number = data[7:0];
				default:        ;
			endcase
		endfunction

		function int clip(int v, int lo, int hi);
			if (v < lo) return lo;
			if (v > hi) return hi;
			return v;
		endfunction

		function int gap(int a, int b);
			return (a >= b) ? a - b : b - a;
		endfunction

		function void note_sample(sample_t s);
			int           speed;
			int           brake;
			int           accel;
			int           abs_a;
			int           tc_a;
			int           rumble_scaled;
			int           shift_scaled;
			int           level [NUM_SET];
			bit           fire;
			setting_msg_t m;
			setting_msg_t run_q [$];
			speed = int'(s.vehicle_speed);
			brake = int'(s.brake_percent);
			accel = int'(s.accel_percent);
			abs_a = int'(s.abs_on);
			tc_a = int'(s.traction_on);
			rumble_scaled = int'(s.rumble_level) * 100 / 255;
			shift_scaled = int'(s.shift_level) * 100 / 255;
			level[0] = clip(6500 + brake * 35 + accel * 20 + abs_a * 500 + tc_a * 300,
				3500, 14000);
			level[1] = clip(80 - speed / 6, 15, 100);
			level[2] = clip(20 + brake / 2 + speed / 25, 0, 100);
			level[3] = clip(rumble_scaled / 2 +
				((s.surface_code == cfg.kerb_surface_code) ? 30 : 0), 0, 100);
			level[4] = clip(abs_a * 25 + tc_a * 20 + brake / 6, 0, 100);
			level[5] = clip(40 + shift_scaled / 4, 0, 100);
			level[6] = clip(20 + brake / 2, 0, 100);
			level[7] = clip(30 + rumble_scaled / 3, 0, 100);
			level[8] = clip(20 + accel / 3, 0, 100);
			for (int i = 0; i < NUM_SET; i++) begin
				if (i == ID_POWER) begin
					fire = !primed || gap(level[i], int'(last_power)) >= int'(cfg.power_deadband);
					if (fire) last_power = level[i][13:0];
				end else begin
					fire = !primed ||
						gap(level[i], int'(last_pct[i-1])) >= int'(cfg.percent_deadband);
					if (fire) last_pct[i-1] = level[i][6:0];
				end
				if (fire) begin
					m.control_id = i[3:0];
					m.setting_value = level[i][13:0];
					m.axis_index = (i <= ID_LAST_AXIS) ? cfg.axis_number : 8'd0;
					m.last_of_run = 1'b0;
					run_q.push_back(m);
				end
			end
			if (run_q.size() > 0) begin
				m = run_q.pop_back();
				m.last_of_run = 1'b1;
				run_q.push_back(m);
			end
			foreach (run_q[i]) pending_q.push_back(run_q[i]);
			primed = 1'b1;
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(setting_msg_t got);
			setting_msg_t want;
			if (pending_q.size() == 0) begin
				$error("result with nothing expected: control_id %0d setting_value %0d",
					got.control_id, got.setting_value);
				errors++;
				return;
			end
			want = pending_q.pop_front();
			compare_field("control_id", int'(want.control_id), int'(got.control_id));
			compare_field("setting_value", int'(want.setting_value), int'(got.setting_value));
			compare_field("axis_index", int'(want.axis_index), int'(got.axis_index));
			compare_field("last_of_run", int'(want.last_of_run), int'(got.last_of_run));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [13:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [9:0]  vehicle_speed = '0;
	logic [6:0]  brake_percent = '0;
	logic [6:0]  accel_percent = '0;
	logic        abs_on = 1'b0;
	logic        traction_on = 1'b0;
	logic [7:0]  rumble_level = '0;
	logic [7:0]  shift_level = '0;
	logic [7:0]  surface_code = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  control_id;
	logic [13:0] setting_value;
	logic [7:0]  axis_index;
	logic        last_of_run;

	feedback_scoreboard sb = new();
	int      in_gap_odds = 0;
	int      out_stall_odds = 0;
	int      stall_left = 0;
	sample_t prev_sample = '0;

	telemetry_to_feedback_deadband u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.vehicle_speed (vehicle_speed),
		.brake_percent (brake_percent),
		.accel_percent (accel_percent),
		.abs_on        (abs_on),
		.traction_on   (traction_on),
		.rumble_level  (rumble_level),
		.shift_level   (shift_level),
		.surface_code  (surface_code),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.control_id    (control_id),
		.setting_value (setting_value),
		.axis_index    (axis_index),
		.last_of_run   (last_of_run)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			out_stall = 1'b1;
		end else if (out_stall_odds > 0 && $urandom_range(0, out_stall_odds) == 0) begin
			stall_left = int'($urandom_range(0, 15));
			out_stall = 1'b1;
		end else begin
			out_stall = 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({control_id, setting_value, axis_index, last_of_run});
	end

	function automatic sample_t mk(int spd, int brk, int acc, int ab, int tc,
		int rmb, int sft, int srf);
		sample_t s;
		s.vehicle_speed = spd[9:0];
		s.brake_percent = brk[6:0];
		s.accel_percent = acc[6:0];
		s.abs_on = ab[0];
		s.traction_on = tc[0];
		s.rumble_level = rmb[7:0];
		s.shift_level = sft[7:0];
		s.surface_code = srf[7:0];
		return s;
	endfunction

	function automatic int nudge(int v, int span, int top);
		int r;
		r = v + int'($urandom_range(0, 2 * span)) - span;
		if (r < 0) r = 0;
		if (r > top) r = top;
		return r;
	endfunction

	function automatic sample_t next_sample(sample_t prev, logic [7:0] kerb);
		sample_t s;
		if ($urandom_range(0, 9) < 4) begin
			s.vehicle_speed = 10'($urandom_range(0, 1023));
			s.brake_percent = 7'($urandom_range(0, 127));
			s.accel_percent = 7'($urandom_range(0, 127));
			s.abs_on = 1'($urandom_range(0, 1));
			s.traction_on = 1'($urandom_range(0, 1));
			s.rumble_level = 8'($urandom_range(0, 255));
			s.shift_level = 8'($urandom_range(0, 255));
			s.surface_code = 8'($urandom_range(0, 255));
		end else begin
			// small drift around the last item keeps changes near the deadbands
			s = prev;
			s.vehicle_speed = 10'(nudge(int'(prev.vehicle_speed), 40, 1023));
			s.brake_percent = 7'(nudge(int'(prev.brake_percent), 8, 127));
			s.accel_percent = 7'(nudge(int'(prev.accel_percent), 12, 127));
			s.rumble_level = 8'(nudge(int'(prev.rumble_level), 20, 255));
			s.shift_level = 8'(nudge(int'(prev.shift_level), 25, 255));
			if ($urandom_range(0, 7) == 0) s.abs_on = ~prev.abs_on;
			if ($urandom_range(0, 7) == 0) s.traction_on = ~prev.traction_on;
		end
		if ($urandom_range(0, 3) == 0) s.surface_code = kerb;
		return s;
	endfunction

	task automatic send_sample(sample_t s);
		int idle;
		if (in_gap_odds > 0 && $urandom_range(0, in_gap_odds) == 0) begin
			idle = int'($urandom_range(1, 16));
			repeat (idle) begin
				@(negedge clk);
				in_valid = 1'b0;
			end
		end
		@(negedge clk);
		in_valid = 1'b1;
		{vehicle_speed, brake_percent, accel_percent, abs_on, traction_on,
			rumble_level, shift_level, surface_code} = s;
		do @(posedge clk); while (in_stall);
		sb.note_sample(s);
		prev_sample = s;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		// an item with no results may still be in flight
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, int data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data[13:0];
		@(negedge clk);
		cfg_we = 1'b0;
		sb.write_reg(idx, data[13:0]);
	endtask

	task automatic set_config(int pdb, int pctdb, int kerb, int axis);
		drain();
		write_reg(REG_POWER_DB, pdb);
		write_reg(REG_PERCENT_DB, pctdb);
		write_reg(REG_KERB_CODE, kerb);
		write_reg(REG_AXIS, axis);
	endtask

	task automatic random_run(int count, int quiet_tail);
		for (int k = 0; k < count; k++) begin
			if (k >= count - quiet_tail) begin
				in_gap_odds = 0;
				out_stall_odds = 0;
			end else if (k % 15 == 0) begin
				case ($urandom_range(0, 2))
					0: in_gap_odds = 0;
					1: in_gap_odds = 2;
					default: in_gap_odds = 6;
				endcase
				case ($urandom_range(0, 2))
					0: out_stall_odds = 0;
					1: out_stall_odds = 3;
					default: out_stall_odds = 10;
				endcase
			end
			send_sample(next_sample(prev_sample, sb.cfg.kerb_surface_code));
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset register values, first item emits everything
		in_gap_odds = 3;
		out_stall_odds = 4;
		send_sample(mk(0, 0, 0, 0, 0, 0, 0, 0));
		send_sample(mk(0, 0, 0, 0, 0, 0, 0, 0));
		send_sample(mk(0, 0, 10, 0, 0, 0, 0, 0));
		send_sample(mk(0, 0, 19, 0, 0, 0, 0, 0));
		send_sample(mk(1023, 127, 127, 1, 1, 255, 255, 255));
		send_sample(mk(389, 100, 100, 0, 1, 128, 128, 1));
		send_sample(mk(390, 100, 100, 0, 1, 128, 128, 1));
		send_sample(mk(390, 100, 100, 0, 1, 255, 128, 1));
		send_sample(mk(0, 0, 0, 1, 0, 0, 0, 0));
		send_sample(mk(0, 0, 0, 0, 1, 0, 0, 0));
		send_sample(mk(1023, 0, 0, 0, 0, 0, 0, 0));
		send_sample(mk(0, 0, 0, 0, 0, 255, 0, 0));
		send_sample(mk(0, 0, 0, 0, 0, 0, 255, 0));
		send_sample(mk(0, 127, 0, 0, 0, 0, 0, 2));
		send_sample(mk(0, 0, 127, 0, 0, 0, 0, 1));
		send_sample(mk(512, 64, 64, 1, 1, 170, 85, 1));

		// zero deadbands, every setting on every item
		set_config(0, 0, 0, 255);
		send_sample(mk(512, 64, 64, 1, 1, 170, 85, 0));
		send_sample(mk(512, 64, 64, 1, 1, 170, 85, 0));
		random_run(30, 0);

		// widest deadbands, nothing is sent
		set_config(16383, 127, 255, 128);
		random_run(20, 0);

		set_config(int'($urandom_range(0, 400)), int'($urandom_range(0, 10)),
			int'($urandom_range(0, 255)), int'($urandom_range(0, 255)));
		random_run(25, 0);

		set_config(200, 3, 1, int'($urandom_range(0, 255)));
		random_run(30, 20);

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#5ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule

@@ files.f @@
sv/ttfd_pkg.sv
sv/ttfd_front.sv
sv/ttfd_queue.sv
sv/ttfd_back.sv
sv/telemetry_to_feedback_deadband.sv
sv/ttfd_checker.sv
test/tb_telemetry_to_feedback_deadband.sv
